/* rtl/sorted_unique_set_core_defines.svh */
`ifndef SORTED_UNIQUE_SET_CORE_DEFINES_SVH
`define SORTED_UNIQUE_SET_CORE_DEFINES_SVH

// Same-cycle check, sampled on clk, off while rst_n is low.
`define SUS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check, sampled on clk, off while rst_n is low.
`define SUS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sus_pkg.sv */
`default_nettype none

package sus_pkg;

    localparam int DATA_W      = 32;
    localparam int OPCODE_W    = 2;
    localparam int RANK_W      = 5;
    localparam int COUNT_W     = 6;
    localparam int OP_READ_BIT = 1;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_READ_OK   = 3'd5,
        ST_RANK_BAD  = 3'd6
    } status_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]      opcode;
        logic signed [DATA_W-1:0] value;
        logic [RANK_W-1:0]        rank;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] read_value;
    } rsp_t;

    typedef enum logic [1:0] {
        RD_PTR,
        RD_PTR_DEC,
        RD_PTR_INC,
        RD_RANK
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_RESOLVE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    capture;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        logic    wr_value;
        logic    ptr_inc;
        logic    ptr_dec;
        logic    ptr_load_count;
        logic    rpos_save;
        logic    found_load;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_status;
        status_t status;
        logic    load_out;
    } sus_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic op_read;
        logic op_insert;
        logic rank_ok;
        logic ptr_at_count;
        logic ptr_at_rpos;
        logic ptr_last;
        logic less;
        logic found;
        logic full;
        logic out_free;
    } sus_stat_t;

endpackage

`default_nettype wire

/* rtl/sus_stream_if.sv */
`default_nettype none

interface sus_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/sorted_unique_set_core.sv */
// Sorted set of signed values, ascending, no duplicates, CAPACITY entries.
// cmd channel: one beat per operation (opcode, value, rank); opcode 0 inserts,
// 1 deletes, 2 or 3 reads the entry at the given ascending rank.
// rsp channel: exactly one beat per cmd beat, in order, carrying the status,
// the live count after the operation and, on a good read, the entry.
// One operation is in flight at a time; cmd.ready is high only while idle.
// A read goes straight to the result; the other operations first search from
// entry 0 upward, stopping at the count or at the first entry not below the
// value, and an insert or delete then moves the entries past the slot one by one.
// The entry table is a single memory with one read and one write port,
// scanned and shifted one entry per step.
// The result sits in an output register; a new cmd beat is taken while it
// waits, but the next result holds until rsp.ready frees that register.
// Reset empties the set at once (count zero); no clearing pass is needed.
`default_nettype none
`include "sorted_unique_set_core_defines.svh"

module sorted_unique_set_core #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32
) (
    input wire logic    clk,
    input wire logic    rst_n,
    sus_stream_if.sink  cmd,
    sus_stream_if.source rsp
);
    import sus_pkg::*;

    sus_ctl_t  ctl;
    sus_stat_t stat;
    logic      in_ready;
    logic      rsp_valid;
    rsp_t      rsp_payload;

    sus_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    sus_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (cmd.payload),
        .rsp_payload (rsp_payload),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp.ready),
        .ctl         (ctl),
        .stat        (stat)
    );

    assign cmd.ready   = in_ready;
    assign rsp.valid   = rsp_valid;
    assign rsp.payload = rsp_payload;

    `SUS_ASSERT_NEXT(a_one_in_flight, cmd.valid && cmd.ready, !cmd.ready,
        "new operation accepted while one is in flight")
    `SUS_ASSERT_NOW(a_load_when_free, ctl.load_out, stat.out_free,
        "result overwritten before it was taken")
    `SUS_ASSERT_NOW(a_zero_read_value,
        rsp.valid && (rsp.payload.status != ST_READ_OK),
        rsp.payload.read_value == '0,
        "read_value nonzero on a result that is not a read")
    `SUS_ASSERT_NOW(a_no_write_on_full, stat.full && stat.op_insert, !ctl.cnt_inc,
        "insert stored into a full table")

endmodule

`default_nettype wire

/* rtl/sus_ctrl.sv */
`default_nettype none

module sus_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sus_pkg::sus_stat_t stat,
    output sus_pkg::sus_ctl_t       ctl
);
    import sus_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.op_read)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SEARCH_RD;
                end
            end
            S_SEARCH_RD:
            begin
                if (stat.ptr_at_count)
                begin
                    state_next = S_RESOLVE;
                end
                else
                begin
                    state_next = S_SEARCH_CMP;
                end
            end
            S_SEARCH_CMP:
            begin
                if (stat.less)
                begin
                    state_next = S_SEARCH_RD;
                end
                else
                begin
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                if (stat.op_insert)
                begin
                    if (stat.found || stat.full)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
                else if (stat.found)
                begin
                    state_next = S_DEL_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.ptr_at_rpos)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                state_next = S_SHIFT_RD;
            end
            S_DEL_RD:
            begin
                if (stat.ptr_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                state_next = S_DEL_RD;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.capture = in_valid;
            end
            S_DISPATCH:
            begin
                if (stat.op_read)
                begin
                    ctl.set_status = 1'b1;
                    if (stat.rank_ok)
                    begin
                        ctl.rd_en  = 1'b1;
                        ctl.rd_sel = RD_RANK;
                        ctl.status = ST_READ_OK;
                    end
                    else
                    begin
                        ctl.status = ST_RANK_BAD;
                    end
                end
            end
            S_SEARCH_RD:
            begin
                if (!stat.ptr_at_count)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_PTR;
                end
            end
            S_SEARCH_CMP:
            begin
                if (stat.less)
                begin
                    ctl.ptr_inc = 1'b1;
                end
                else
                begin
                    ctl.found_load = 1'b1;
                end
            end
            S_RESOLVE:
            begin
                if (stat.op_insert)
                begin
                    if (stat.found)
                    begin
                        ctl.set_status = 1'b1;
                        ctl.status     = ST_DUPLICATE;
                    end
                    else if (stat.full)
                    begin
                        ctl.set_status = 1'b1;
                        ctl.status     = ST_FULL;
                    end
                    else
                    begin
                        // remember the slot, then shift down from the top
                        ctl.rpos_save      = 1'b1;
                        ctl.ptr_load_count = 1'b1;
                    end
                end
                else if (!stat.found)
                begin
                    ctl.set_status = 1'b1;
                    ctl.status     = ST_NOT_FOUND;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.ptr_at_rpos)
                begin
                    ctl.wr_en      = 1'b1;
                    ctl.wr_value   = 1'b1;
                    ctl.cnt_inc    = 1'b1;
                    ctl.set_status = 1'b1;
                    ctl.status     = ST_INSERTED;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_PTR_DEC;
                end
            end
            S_SHIFT_WR:
            begin
                ctl.wr_en   = 1'b1;
                ctl.ptr_dec = 1'b1;
            end
            S_DEL_RD:
            begin
                if (stat.ptr_last)
                begin
                    ctl.cnt_dec    = 1'b1;
                    ctl.set_status = 1'b1;
                    ctl.status     = ST_DELETED;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_PTR_INC;
                end
            end
            S_DEL_WR:
            begin
                ctl.wr_en   = 1'b1;
                ctl.ptr_inc = 1'b1;
            end
            S_FINISH:
            begin
                ctl.load_out = stat.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/sus_datapath.sv */
`default_nettype none

module sus_datapath #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sus_pkg::req_t     req,
    output sus_pkg::rsp_t          rsp_payload,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    input  wire sus_pkg::sus_ctl_t ctl,
    output sus_pkg::sus_stat_t     stat
);
    import sus_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    logic [VALUE_BITS-1:0] mem [CAPACITY];

    logic [OPCODE_W-1:0]   op_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [RANK_W-1:0]     rank_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      ptr_reg;
    logic [CNT_W-1:0]      rpos_reg;
    logic                  found_reg;
    logic [VALUE_BITS-1:0] rdata_reg;
    status_t               status_reg;
    logic                  out_valid_reg;
    rsp_t                  out_reg;

    logic [CNT_W-1:0]      ptr_dec;
    logic [CNT_W-1:0]      ptr_inc;
    logic [IDX_W-1:0]      rd_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  out_free;
    rsp_t                  out_next;

    assign ptr_dec = ptr_reg - CNT_W'(1);
    assign ptr_inc = ptr_reg + CNT_W'(1);
    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        case (ctl.rd_sel)
            RD_PTR:     rd_addr = ptr_reg[IDX_W-1:0];
            RD_PTR_DEC: rd_addr = ptr_dec[IDX_W-1:0];
            RD_PTR_INC: rd_addr = ptr_inc[IDX_W-1:0];
            RD_RANK:    rd_addr = IDX_W'(rank_reg);
            default:    rd_addr = ptr_reg[IDX_W-1:0];
        endcase
    end

    assign wr_data = ctl.wr_value ? val_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ptr_reg[IDX_W-1:0]] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg   <= req.opcode;
            val_reg  <= VALUE_BITS'({{VALUE_BITS{1'b0}}, req.value});
            rank_reg <= req.rank;
        end
        if (ctl.rpos_save)
        begin
            rpos_reg <= ptr_reg;
        end
        if (ctl.set_status)
        begin
            status_reg <= ctl.status;
        end
        if (ctl.load_out)
        begin
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        out_next.status     = status_reg;
        out_next.count      = COUNT_W'(count_reg);
        out_next.read_value = '0;
        if (status_reg == ST_READ_OK)
        begin
            out_next.read_value = DATA_W'({{DATA_W{1'b0}}, rdata_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.cnt_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (ctl.cnt_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end

            if (ctl.capture)
            begin
                ptr_reg <= '0;
            end
            else if (ctl.ptr_load_count)
            begin
                ptr_reg <= count_reg;
            end
            else if (ctl.ptr_inc)
            begin
                ptr_reg <= ptr_inc;
            end
            else if (ctl.ptr_dec)
            begin
                ptr_reg <= ptr_dec;
            end

            if (ctl.capture)
            begin
                found_reg <= 1'b0;
            end
            else if (ctl.found_load)
            begin
                found_reg <= (rdata_reg == val_reg);
            end

            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.op_read      = op_reg[OP_READ_BIT];
    assign stat.op_insert    = (op_reg == OP_INSERT);
    assign stat.rank_ok      = CMP_W'(rank_reg) < CMP_W'(count_reg);
    assign stat.ptr_at_count = (ptr_reg == count_reg);
    assign stat.ptr_at_rpos  = (ptr_reg == rpos_reg);
    assign stat.ptr_last     = (ptr_inc == count_reg);
    assign stat.less         = $signed(rdata_reg) < $signed(val_reg);
    assign stat.found        = found_reg;
    assign stat.full         = (count_reg == CNT_W'(CAPACITY));
    assign stat.out_free     = out_free;

    assign rsp_valid   = out_valid_reg;
    assign rsp_payload = out_reg;

endmodule

`default_nettype wire
